// ===== rtl/pts_pkg.sv =====
package pts_pkg;

    localparam int MAX_TERMS = 32;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DATA_W    = 32;
    localparam int EPS_W     = 31;
    localparam int TERM_W    = 6;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_EPS = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER = 1'b0,
        CFG_EPS    = 1'b1
    } t_cfg_idx;

    // one run handed from front to back
    typedef struct packed {
        t_status           status;
        logic [CNT_W-1:0]  n;
    } t_cmd;

    // coefficient store write from the front
    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        addr;
        logic signed [DATA_W-1:0] data;
    } t_store_wr;

    typedef struct packed {
        logic signed [DATA_W-1:0] coeff;
        logic [TERM_W-1:0]        idx;
        logic                     last;
        t_status                  status;
    } t_result;

endpackage

// ===== rtl/polynomial_taylor_shift.sv =====
// channel   | handshake        | payload
// ----------+------------------+---------------------------------------------------
// coeff in  | push / full      | i_coeff_in, i_last_coeff
// result    | pop / empty      | o_shifted_coeff, o_term_index, o_last_result, o_status
// config    | i_cfg_we         | i_cfg_idx, i_cfg_wdata
//
// a coefficient beat is taken while push is high and full is low; the beat marked last starts a run
// a run works through the horner step loop on one shared 32x32 multiplier, each step
// an S_MUL state then an S_ADD state, with the fetch, load and emit states around the loop
// full stays high while a run owns the coefficient store; error runs give one beat
// reset (i_rst_n low, synchronous) clears counts, queues and sets the registers to default
// results wait in a two-beat queue, so pop may stall without losing work
module polynomial_taylor_shift (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [pts_pkg::DATA_W-1:0]    i_coeff_in,
    input  logic                                 i_last_coeff,
    input  logic                                 pop,
    output logic                                 empty,
    output logic signed [pts_pkg::DATA_W-1:0]    o_shifted_coeff,
    output logic [pts_pkg::TERM_W-1:0]           o_term_index,
    output logic                                 o_last_result,
    output logic [1:0]                           o_status,
    input  logic                                 i_cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pts_pkg::DATA_W-1:0]           i_cfg_wdata
);

    logic signed [pts_pkg::DATA_W-1:0] r_center;
    logic [pts_pkg::EPS_W-1:0]         r_eps;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    pts_pkg::t_cmd      cmd_in;
    pts_pkg::t_cmd      cmd_out;
    pts_pkg::t_store_wr store_wr;
    pts_pkg::t_result   result;
    logic               run_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_eps    <= pts_pkg::EPS_W'(66);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pts_pkg::CFG_CENTER: r_center <= i_cfg_wdata;
                pts_pkg::CFG_EPS:    r_eps    <= i_cfg_wdata[pts_pkg::EPS_W-1:0];
                default:             r_eps    <= r_eps;
            endcase
        end
    end

    pts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_coeff    (i_coeff_in),
        .i_last     (i_last_coeff),
        .i_eps_zero (r_eps == '0),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_cmd      (cmd_in),
        .o_store    (store_wr),
        .i_run_done (run_done)
    );

    pts_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (cmd_out)
    );

    pts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (q_pop),
        .i_store     (store_wr),
        .i_center    (r_center),
        .i_eps       (r_eps),
        .o_run_done  (run_done),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign o_shifted_coeff = result.coeff;
    assign o_term_index    = result.idx;
    assign o_last_result   = result.last;
    assign o_status        = result.status;

endmodule

// ===== rtl/pts_cmdq.sv =====
module pts_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pts_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pts_pkg::t_cmd o_cmd
);

    pts_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push_acc;
    logic          pop_acc;

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_cmd    = r_q[r_rp];
    assign push_acc = i_push && !o_full;
    assign pop_acc  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_acc) begin
                r_wp <= !r_wp;
            end
            if (pop_acc) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push_acc) - 2'(pop_acc);
        end
        if (push_acc) begin
            r_q[r_wp] <= i_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("cmd queue popped while empty");
`endif

endmodule

// ===== rtl/pts_front.sv =====
module pts_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic signed [pts_pkg::DATA_W-1:0] i_coeff,
    input  logic                             i_last,
    input  logic                             i_eps_zero,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output pts_pkg::t_cmd                    o_cmd,
    output pts_pkg::t_store_wr               o_store,
    input  logic                             i_run_done
);

    localparam int CW = pts_pkg::CNT_W;
    localparam int AW = pts_pkg::ADDR_W;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_lock;
    logic          accept;
    logic          room;
    logic          ovf_now;

    // the store is owned by the back while an ok run is queued or running
    assign o_full  = i_q_full || r_lock;
    assign accept  = i_push && !o_full;
    assign room    = (r_count < CW'(pts_pkg::MAX_TERMS));
    assign ovf_now = r_ovf || !room;

    assign o_store.we   = accept && room;
    assign o_store.addr = r_count[AW-1:0];
    assign o_store.data = i_coeff;

    assign o_q_push = accept && i_last;

    always_comb begin
        o_cmd.n = r_count + CW'(1);
        priority if (ovf_now) begin
            o_cmd.status = pts_pkg::ST_OVF;
        end else if (i_eps_zero) begin
            o_cmd.status = pts_pkg::ST_EPS;
        end else begin
            o_cmd.status = pts_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_lock  <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_lock  <= (o_cmd.status == pts_pkg::ST_OK);
                end else if (room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (i_run_done) begin
                r_lock <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_store.we |-> !r_lock) else $error("store written during a run");
    a_done_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_run_done |-> r_lock) else $error("run finished with store unlocked");
`endif

endmodule

// ===== rtl/pts_back.sv =====
module pts_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  pts_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_pop,
    input  pts_pkg::t_store_wr                i_store,
    input  logic signed [pts_pkg::DATA_W-1:0] i_center,
    input  logic [pts_pkg::EPS_W-1:0]         i_eps,
    output logic                              o_run_done,
    output logic                              o_empty,
    input  logic                              i_pop,
    output pts_pkg::t_result                  o_result
);

    localparam int CW = pts_pkg::CNT_W;
    localparam int AW = pts_pkg::ADDR_W;
    localparam int DW = pts_pkg::DATA_W;
    localparam int PW = 2 * DW - pts_pkg::FRAC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_ADD,
        S_EMIT
    } t_state;

    // working coefficient array, also the input store
    logic signed [DW-1:0] r_mem [pts_pkg::MAX_TERMS];
    logic signed [DW-1:0] r_rdata;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic signed [DW-1:0] mem_wd;

    t_state               r_state, n_state;
    pts_pkg::t_status     r_status, n_status;
    logic [CW-1:0]        r_n, n_n;
    logic [AW-1:0]        r_i, n_i;
    logic [AW-1:0]        r_wa, n_wa;
    logic signed [DW-1:0] r_top, n_top;
    logic signed [DW-1:0] r_carry, n_carry;
    logic signed [DW-1:0] r_low, n_low;
    logic signed [PW-1:0] r_prod, n_prod;
    logic signed [DW-1:0] r_b, n_b;

    logic signed [2*DW-1:0] full_prod;
    logic signed [PW:0]     sum;
    logic signed [DW-1:0]   sat_sum;
    logic [DW-1:0]          mag;
    logic                   is_last;
    logic                   back_we;

    pts_pkg::t_result r_oq [2];
    logic             r_oq_wp;
    logic             r_oq_rp;
    logic [1:0]       r_oq_cnt;
    logic             oq_push;
    logic             oq_pop;
    pts_pkg::t_result emit_res;

    assign full_prod = r_carry * i_center;
    // arithmetic shift of the product gives the floor
    assign sum = (PW+1)'(r_low) + (PW+1)'(r_prod);
    assign sat_sum = (sum[PW:DW-1] == {(PW-DW+2){sum[PW]}}) ? sum[DW-1:0]
                   : (sum[PW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});
    assign mag = r_b[DW-1] ? (DW'(0) - r_b) : r_b;
    assign is_last = (r_status != pts_pkg::ST_OK) || ((CW'(r_i) + CW'(1)) == r_n);

    always_comb begin
        emit_res.coeff = (r_status == pts_pkg::ST_OK && mag < {1'b0, i_eps}) ? '0 : r_b;
        emit_res.idx    = pts_pkg::TERM_W'(r_i);
        emit_res.last   = is_last;
        emit_res.status = r_status;
    end

    assign oq_push = (r_state == S_EMIT) && (r_oq_cnt != 2'd2);
    assign oq_pop  = i_pop && (r_oq_cnt != 2'd0);
    assign o_empty = (r_oq_cnt == 2'd0);
    assign o_result = r_oq[r_oq_rp];
    assign o_run_done = oq_push && is_last && (r_status == pts_pkg::ST_OK);

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_n       = r_n;
        n_i       = r_i;
        n_wa      = r_wa;
        n_top     = r_top;
        n_carry   = r_carry;
        n_low     = r_low;
        n_prod    = r_prod;
        n_b       = r_b;
        rd_addr   = r_wa;
        back_we   = 1'b0;
        o_cmd_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_n       = i_cmd.n;
                    n_status  = i_cmd.status;
                    n_i       = '0;
                    n_b       = '0;
                    rd_addr   = AW'(i_cmd.n - CW'(1));
                    n_state   = (i_cmd.status == pts_pkg::ST_OK) ? S_LOAD : S_EMIT;
                end
            end
            S_LOAD: begin
                n_top   = r_rdata;
                n_carry = r_rdata;
                if (r_n == CW'(1)) begin
                    n_b     = r_rdata;
                    n_state = S_EMIT;
                end else begin
                    n_wa    = AW'(r_n - CW'(2));
                    rd_addr = AW'(r_n - CW'(2));
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_low   = r_rdata;
                n_prod  = full_prod[2*DW-1:pts_pkg::FRAC_W];
                n_state = S_ADD;
            end
            S_ADD: begin
                // one horner step: w[j-1] += floor(w[j] * a), saturated to 32 bits
                back_we = 1'b1;
                n_carry = sat_sum;
                if (r_wa == r_i) begin
                    n_b     = sat_sum;
                    n_state = S_EMIT;
                end else begin
                    n_wa    = r_wa - AW'(1);
                    rd_addr = r_wa - AW'(1);
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (oq_push) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_carry = r_top;
                        // top coefficient never changes, so the final pass needs no step
                        if ((CW'(r_i) + CW'(2)) == r_n) begin
                            n_b = r_top;
                        end else begin
                            n_wa    = AW'(r_n - CW'(2));
                            rd_addr = AW'(r_n - CW'(2));
                            n_state = S_MUL;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign mem_we = back_we || i_store.we;
    assign mem_wa = back_we ? r_wa : i_store.addr;
    assign mem_wd = back_we ? sat_sum : i_store.data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            r_state <= n_state;
            if (oq_push) begin
                r_oq_wp <= !r_oq_wp;
            end
            if (oq_pop) begin
                r_oq_rp <= !r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + 2'(oq_push) - 2'(oq_pop);
        end
        r_status <= n_status;
        r_n      <= n_n;
        r_i      <= n_i;
        r_wa     <= n_wa;
        r_top    <= n_top;
        r_carry  <= n_carry;
        r_low    <= n_low;
        r_prod   <= n_prod;
        r_b      <= n_b;
        if (oq_push) begin
            r_oq[r_oq_wp] <= emit_res;
        end
    end

`ifndef ASSERT_OFF
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt != 2'd3) else $error("result queue count out of range");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_wa >= r_i)) else $error("horner step below pass index");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE)) else $error("command taken mid run");
`endif

endmodule
